// ===== rtl/hvg_pkg.sv =====
package hvg_pkg;

    // field and datapath widths
    localparam int IDX_W      = 12;
    localparam int N_W        = 11;
    localparam int A_W        = 16;
    localparam int C_W        = 24;
    localparam int R_W        = 15;
    localparam int NUM_W      = 27;
    localparam int DEN_W      = 12;
    localparam int QUO_W      = 16;
    localparam int T_W        = 17;
    localparam int Q_W        = 5;
    localparam int QMAG_W     = 4;
    localparam int Z_W        = 32;
    localparam int XY_W       = 34;
    localparam int EXP_W      = 44;
    localparam int PROD_W     = 61;
    localparam int AC_W       = PROD_W - 28;
    localparam int SUM_W      = AC_W + 2;
    localparam int OUT_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // segments per branch are clamped to this
    localparam int MAX_STEPS  = 1024;

    // largest ln2 multiple that a Q4.12 parameter can reach
    localparam int QMAX       = 12;

    localparam logic [31:0] LN2_Q28  = 32'd186065279;
    localparam logic [31:0] LN2_HALF = LN2_Q28 / 2;

    localparam int CORDIC_ITERATIONS_DEF = 20;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SEMI_A    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEMI_B    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_H  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_K  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_VERTICAL  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_RNG  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_STEPS     = 3'd6;

    // register reset values
    localparam logic [A_W-1:0] SEMI_A_RST   = 16'd256;
    localparam logic [A_W-1:0] SEMI_B_RST   = 16'd256;
    localparam logic [R_W-1:0] HALF_RNG_RST = 15'd8192;
    localparam logic [N_W-1:0] STEPS_RST    = 11'd64;

    // per-vertex flags that ride along the pipeline
    typedef struct packed {
        logic err;
        logic restart;
        logic last;
        logic neg;
    } side_t;

    typedef struct packed {
        side_t                  side;
        logic signed [Q_W-1:0]  q;
    } cordic_tag_t;

    // shift of cordic iteration idx: 1,2,3,4,4,5,..,13,13,..
    function automatic int cordic_shift(input int idx);
        int k;
        int rep;
        int s;
        logic again;
        k = 1;
        rep = 4;
        s = 1;
        again = 1'b0;
        for (int it = 0; it <= idx; it++) begin
            s = k;
            if (s == rep && !again) begin
                again = 1'b1;
            end
            else begin
                if (s == rep) begin
                    rep = 3 * rep + 1;
                end
                again = 1'b0;
                k = k + 1;
            end
        end
        return s;
    endfunction

    // atanh(2^-s) in Q28 from the truncated Q62 series
    function automatic logic [63:0] atanh_q28(input int s);
        logic [63:0] sum;
        int e;
        sum = 64'd0;
        for (int m = 0; m < 32; m++) begin
            e = 62 - s * (2 * m + 1);
            if (e >= 0) begin
                sum = sum + ((64'd1 << e) / 64'(2 * m + 1));
            end
        end
        return (sum + (64'd1 << 33)) >> 34;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        logic [63:0] val;
        res = 64'd0;
        bt = 64'd1 << 62;
        val = v;
        for (int i = 0; i < 32; i++) begin
            if (bt > val) begin
                bt = bt >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bt != 64'd0) begin
                if (val >= res + bt) begin
                    val = val - (res + bt);
                    res = (res >> 1) + bt;
                end
                else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        return res;
    endfunction

    // cordic gain in Q31
    function automatic logic [63:0] cordic_gain(input int iters);
        logic [63:0] p;
        logic [63:0] kq;
        int s;
        p = 64'd1 << 62;
        for (int it = 0; it < iters; it++) begin
            s = cordic_shift(it);
            p = p - (p >> (2 * s));
        end
        kq = isqrt64(p);
        if (kq == 64'd0) begin
            kq = 64'd1;
        end
        return kq;
    endfunction

endpackage

// ===== rtl/hvg_div_pipe.sv =====
module hvg_div_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [hvg_pkg::NUM_W-1:0]   in_num,
    input  logic [hvg_pkg::DEN_W-1:0]   den,
    input  hvg_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [hvg_pkg::QUO_W-1:0]   out_quot,
    output hvg_pkg::side_t              out_side
);
    import hvg_pkg::*;

    localparam int TRIAL_W = NUM_W + 1;

    logic              valid_reg [QUO_W];
    logic [NUM_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  quot_reg  [QUO_W];
    side_t             side_reg  [QUO_W];

    logic              valid_next [QUO_W];
    logic [NUM_W-1:0]  rem_next   [QUO_W];
    logic [QUO_W-1:0]  quot_next  [QUO_W];
    side_t             side_next  [QUO_W];

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        localparam int B = QUO_W - 1 - i;
        logic [NUM_W-1:0]   rem_in;
        logic [QUO_W-1:0]   quot_in;
        logic [TRIAL_W-1:0] den_sh;
        logic [TRIAL_W-1:0] diff;
        logic               ge;

        if (i == 0) begin : g_first
            assign rem_in        = in_num;
            assign quot_in       = '0;
            assign valid_next[i] = in_valid;
            assign side_next[i]  = in_side;
        end
        else begin : g_rest
            assign rem_in        = rem_reg[i-1];
            assign quot_in       = quot_reg[i-1];
            assign valid_next[i] = valid_reg[i-1];
            assign side_next[i]  = side_reg[i-1];
        end

        assign den_sh       = TRIAL_W'(den) << B;
        assign diff         = {1'b0, rem_in} - den_sh;
        assign ge           = ~diff[TRIAL_W-1];
        assign rem_next[i]  = ge ? diff[NUM_W-1:0] : rem_in;
        assign quot_next[i] = quot_in | (QUO_W'(ge) << B);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                quot_reg[i] <= quot_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quot  = quot_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

// ===== rtl/hvg_cordic_pipe.sv =====
module hvg_cordic_pipe #(
    parameter int ITER = hvg_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [hvg_pkg::Z_W-1:0]    in_z,
    input  hvg_pkg::cordic_tag_t              in_tag,
    output logic                              out_valid,
    output logic signed [hvg_pkg::XY_W-1:0]   out_x,
    output logic signed [hvg_pkg::XY_W-1:0]   out_y,
    output hvg_pkg::cordic_tag_t              out_tag
);
    import hvg_pkg::*;

    // start value 1/K in Q28
    localparam logic [63:0] X0 = (64'd1 << 59) / cordic_gain(ITER);

    logic                    valid_reg [ITER];
    logic signed [XY_W-1:0]  x_reg     [ITER];
    logic signed [XY_W-1:0]  y_reg     [ITER];
    logic signed [Z_W-1:0]   z_reg     [ITER];
    cordic_tag_t             tag_reg   [ITER];

    logic                    valid_next [ITER];
    logic signed [XY_W-1:0]  x_next     [ITER];
    logic signed [XY_W-1:0]  y_next     [ITER];
    logic signed [Z_W-1:0]   z_next     [ITER];
    cordic_tag_t             tag_next   [ITER];

    // one rotation mode micro-rotation per stage
    for (genvar i = 0; i < ITER; i++) begin : g_stage
        localparam int SH = cordic_shift(i);
        localparam logic [63:0] ATH = atanh_q28(SH);
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [Z_W-1:0]  ath;
        logic                   up;

        if (i == 0) begin : g_first
            assign x_in          = XY_W'(X0);
            assign y_in          = '0;
            assign z_in          = in_z;
            assign valid_next[i] = in_valid;
            assign tag_next[i]   = in_tag;
        end
        else begin : g_rest
            assign x_in          = x_reg[i-1];
            assign y_in          = y_reg[i-1];
            assign z_in          = z_reg[i-1];
            assign valid_next[i] = valid_reg[i-1];
            assign tag_next[i]   = tag_reg[i-1];
        end

        assign dx  = y_in >>> SH;
        assign dy  = x_in >>> SH;
        assign ath = Z_W'(ATH);
        assign up  = ~z_in[Z_W-1];

        assign x_next[i] = up ? x_in + dx : x_in - dx;
        assign y_next[i] = up ? y_in + dy : y_in - dy;
        assign z_next[i] = up ? z_in - ath : z_in + ath;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ITER; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < ITER; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ITER; i++)
            begin
                x_reg[i]   <= x_next[i];
                y_reg[i]   <= y_next[i];
                z_reg[i]   <= z_next[i];
                tag_reg[i] <= tag_next[i];
            end
        end
    end

    assign out_valid = valid_reg[ITER-1];
    assign out_x     = x_reg[ITER-1];
    assign out_y     = y_reg[ITER-1];
    assign out_tag   = tag_reg[ITER-1];

endmodule

// ===== rtl/hyperbola_two_branch_vertex_gen.sv =====
// Two-branch hyperbola vertex generator.
// Input channel: in_valid/in_ready carry one vertex_index per transaction.
// Output channel: out_valid/out_ready carry pos_x, pos_y (Q24.8, saturated)
// and the restart, last_vertex and index_error flags, one per input.
// Configuration: cfg_wr_en with cfg_addr/cfg_wdata writes one register in a
// cycle; write only while no vertex is in flight.
// From acceptance to out_valid a vertex passes one decode stage, sixteen
// stages of the restoring divider (one quotient bit each), three range
// reduction stages, one stage per cordic iteration, four stages for
// exponent scaling, multiply and saturation, and the output register.
// Throughput is one vertex per cycle while in_ready is high. A two-entry
// output buffer (output register plus skid register) lets the pipeline take a
// new vertex while a result waits; the whole pipeline holds only once both
// entries are full, so in_ready is low exactly while the skid register is full.
// Reset clears all valid bits and loads the register defaults
// (a = b = 1.0, center 0, horizontal axis, R = 2.0, 64 steps).
module hyperbola_two_branch_vertex_gen #(
    parameter int CORDIC_ITERATIONS = hvg_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [hvg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [hvg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hvg_pkg::IDX_W-1:0]           vertex_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hvg_pkg::OUT_W-1:0]    pos_x,
    output logic signed [hvg_pkg::OUT_W-1:0]    pos_y,
    output logic                                restart,
    output logic                                last_vertex,
    output logic                                index_error
);
    import hvg_pkg::*;

    // configuration registers
    logic [A_W-1:0]         semi_a_reg;
    logic [A_W-1:0]         semi_b_reg;
    logic signed [C_W-1:0]  center_h_reg;
    logic signed [C_W-1:0]  center_k_reg;
    logic                   vertical_reg;
    logic [R_W-1:0]         half_rng_reg;
    logic [N_W-1:0]         steps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            semi_a_reg   <= SEMI_A_RST;
            semi_b_reg   <= SEMI_B_RST;
            center_h_reg <= '0;
            center_k_reg <= '0;
            vertical_reg <= 1'b0;
            half_rng_reg <= HALF_RNG_RST;
            steps_reg    <= STEPS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_SEMI_A:   semi_a_reg   <= cfg_wdata[A_W-1:0];
                REG_SEMI_B:   semi_b_reg   <= cfg_wdata[A_W-1:0];
                REG_CENTER_H: center_h_reg <= cfg_wdata[C_W-1:0];
                REG_CENTER_K: center_k_reg <= cfg_wdata[C_W-1:0];
                REG_VERTICAL: vertical_reg <= cfg_wdata[0];
                REG_HALF_RNG: half_rng_reg <= cfg_wdata[R_W-1:0];
                REG_STEPS:    steps_reg    <= cfg_wdata[N_W-1:0];
                default:      ;
            endcase
        end
    end

    // effective step count
    logic [N_W-1:0] n_eff;
    always_comb
    begin
        if (steps_reg == '0)
            n_eff = N_W'(1);
        else if (steps_reg > N_W'(MAX_STEPS))
            n_eff = N_W'(MAX_STEPS);
        else
            n_eff = steps_reg;
    end

    // pipeline runs whenever the skid register is free
    logic run;
    logic skid_valid_reg;
    assign run      = ~skid_valid_reg;
    assign in_ready = run;

    // decode stage: flags, branch step and divider numerator
    logic                   dec_valid_reg;
    logic [NUM_W-1:0]       dec_num_reg;
    side_t                  dec_side_reg;

    logic [IDX_W:0]         idx_ext;
    logic [IDX_W:0]         end_idx;
    logic [IDX_W:0]         mid_idx;
    logic [IDX_W:0]         j_full;
    logic [N_W-1:0]         j_step;
    logic [NUM_W-2:0]       jr_prod;
    side_t                  dec_side_next;
    logic [NUM_W-1:0]       dec_num_next;

    always_comb
    begin
        idx_ext               = {1'b0, vertex_index};
        end_idx               = (IDX_W+1)'({n_eff, 1'b0}) + (IDX_W+1)'(2);
        mid_idx               = (IDX_W+1)'(n_eff) + (IDX_W+1)'(1);
        dec_side_next.err     = idx_ext > end_idx;
        dec_side_next.restart = ~dec_side_next.err && (idx_ext == mid_idx);
        dec_side_next.neg     = idx_ext > (IDX_W+1)'(n_eff);
        dec_side_next.last    = ~dec_side_next.err && (idx_ext == end_idx);
        j_full                = dec_side_next.neg ? end_idx - idx_ext : idx_ext;
        j_step                = j_full[N_W-1:0];
        jr_prod               = (NUM_W-1)'(j_step) * (NUM_W-1)'(half_rng_reg);
        dec_num_next          = NUM_W'({jr_prod, 1'b0}) + NUM_W'({jr_prod, 1'b0});
        dec_num_next          = dec_num_next + NUM_W'(n_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dec_valid_reg <= 1'b0;
        else if (run)
            dec_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            dec_num_reg  <= dec_num_next;
            dec_side_reg <= dec_side_next;
        end
    end

    // step quotient round(2jR/n) by long division
    logic               div_valid;
    logic [QUO_W-1:0]   div_quot;
    side_t              div_side;

    hvg_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (run),
        .in_valid  (dec_valid_reg),
        .in_num    (dec_num_reg),
        .den       (DEN_W'({n_eff, 1'b0})),
        .in_side   (dec_side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // parameter t in Q4.12
    logic                   t_valid_reg;
    logic signed [T_W-1:0]  t_reg;
    side_t                  t_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_valid_reg <= 1'b0;
        else if (run)
            t_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            t_reg      <= $signed({1'b0, div_quot}) - $signed({2'b00, half_rng_reg});
            t_side_reg <= div_side;
        end
    end

    // ln2 multiple by threshold compare
    logic                   qs_valid_reg;
    logic [QMAG_W-1:0]      qs_mag_reg;
    logic                   qs_neg_reg;
    logic signed [Z_W-1:0]  qs_tq_reg;
    side_t                  qs_side_reg;

    logic [T_W-1:0]         t_abs;
    logic [31:0]            t_round;
    logic [QMAG_W-1:0]      q_count;

    always_comb
    begin
        t_abs   = t_reg[T_W-1] ? T_W'(-t_reg) : T_W'(t_reg);
        t_round = {1'b0, t_abs[R_W-1:0], 16'h0000} + LN2_HALF;
        q_count = '0;
        for (int m = 1; m <= QMAX; m++)
        begin
            if (t_round >= 32'(m) * LN2_Q28)
                q_count = q_count + QMAG_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qs_valid_reg <= 1'b0;
        else if (run)
            qs_valid_reg <= t_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            qs_mag_reg  <= q_count;
            qs_neg_reg  <= t_reg[T_W-1];
            qs_tq_reg   <= $signed({t_reg[15:0], 16'h0000});
            qs_side_reg <= t_side_reg;
        end
    end

    // reduced argument r = t - q*ln2 in Q28
    logic                   rr_valid_reg;
    logic signed [Z_W-1:0]  rr_z_reg;
    cordic_tag_t            rr_tag_reg;

    logic [31:0]            q_ln2;
    cordic_tag_t            rr_tag_next;

    always_comb
    begin
        q_ln2            = 32'(qs_mag_reg) * LN2_Q28;
        rr_tag_next.side = qs_side_reg;
        rr_tag_next.q    = qs_neg_reg ? -$signed({1'b0, qs_mag_reg})
                                      : $signed({1'b0, qs_mag_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rr_valid_reg <= 1'b0;
        else if (run)
            rr_valid_reg <= qs_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            rr_z_reg   <= qs_neg_reg ? qs_tq_reg + $signed(q_ln2)
                                     : qs_tq_reg - $signed(q_ln2);
            rr_tag_reg <= rr_tag_next;
        end
    end

    // cosh r + sinh r and cosh r - sinh r come out as x + y and x - y
    logic                   cor_valid;
    logic signed [XY_W-1:0] cor_x;
    logic signed [XY_W-1:0] cor_y;
    cordic_tag_t            cor_tag;

    hvg_cordic_pipe #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (run),
        .in_valid  (rr_valid_reg),
        .in_z      (rr_z_reg),
        .in_tag    (rr_tag_reg),
        .out_valid (cor_valid),
        .out_x     (cor_x),
        .out_y     (cor_y),
        .out_tag   (cor_tag)
    );

    // scale by 2^(q-1) and 2^(-q-1)
    logic                    ab_valid_reg;
    logic signed [EXP_W-1:0] ab_a_reg;
    logic signed [EXP_W-1:0] ab_b_reg;
    side_t                   ab_side_reg;

    logic signed [EXP_W-1:0] ep;
    logic signed [EXP_W-1:0] em;
    logic signed [Q_W-1:0]   sa;
    logic signed [Q_W-1:0]   sb;
    logic signed [Q_W-1:0]   sa_neg;
    logic signed [Q_W-1:0]   sb_neg;
    logic signed [EXP_W-1:0] a_next;
    logic signed [EXP_W-1:0] b_next;

    always_comb
    begin
        ep     = EXP_W'(cor_x) + EXP_W'(cor_y);
        em     = EXP_W'(cor_x) - EXP_W'(cor_y);
        sa     = cor_tag.q - Q_W'(1);
        sb     = -cor_tag.q - Q_W'(1);
        sa_neg = -sa;
        sb_neg = -sb;
        if (sa[Q_W-1])
            a_next = ep >>> sa_neg[Q_W-2:0];
        else
            a_next = ep <<< sa[Q_W-2:0];
        if (sb[Q_W-1])
            b_next = em >>> sb_neg[Q_W-2:0];
        else
            b_next = em <<< sb[Q_W-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ab_valid_reg <= 1'b0;
        else if (run)
            ab_valid_reg <= cor_valid;
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            ab_a_reg    <= a_next;
            ab_b_reg    <= b_next;
            ab_side_reg <= cor_tag.side;
        end
    end

    // cosh and sinh in Q28
    logic                    cs_valid_reg;
    logic signed [EXP_W-1:0] cs_ch_reg;
    logic signed [EXP_W-1:0] cs_sh_reg;
    side_t                   cs_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cs_valid_reg <= 1'b0;
        else if (run)
            cs_valid_reg <= ab_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            cs_ch_reg   <= ab_a_reg + ab_b_reg;
            cs_sh_reg   <= ab_a_reg - ab_b_reg;
            cs_side_reg <= ab_side_reg;
        end
    end

    // a*cosh and b*sinh
    logic                     mu_valid_reg;
    logic signed [PROD_W-1:0] mu_a_reg;
    logic signed [PROD_W-1:0] mu_b_reg;
    side_t                    mu_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mu_valid_reg <= 1'b0;
        else if (run)
            mu_valid_reg <= cs_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            mu_a_reg    <= PROD_W'($signed({1'b0, semi_a_reg})) * PROD_W'(cs_ch_reg);
            mu_b_reg    <= PROD_W'($signed({1'b0, semi_b_reg})) * PROD_W'(cs_sh_reg);
            mu_side_reg <= cs_side_reg;
        end
    end

    // round to Q8, add the center, saturate; restart and error vertices give zero
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic ovf;
        ovf = (v[SUM_W-1:OUT_W-1] != '0) && (v[SUM_W-1:OUT_W-1] != '1);
        if (!ovf)
            return v[OUT_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    logic                     fn_valid_reg;
    logic signed [OUT_W-1:0]  fn_x_reg;
    logic signed [OUT_W-1:0]  fn_y_reg;
    side_t                    fn_side_reg;

    logic signed [PROD_W-1:0] rnd_a;
    logic signed [PROD_W-1:0] rnd_b;
    logic signed [AC_W:0]     ac;
    logic signed [AC_W:0]     bs;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic signed [OUT_W-1:0]  fn_x_next;
    logic signed [OUT_W-1:0]  fn_y_next;

    always_comb
    begin
        rnd_a = mu_a_reg + PROD_W'(64'd1 << 27);
        rnd_b = mu_b_reg + PROD_W'(64'd1 << 27);
        ac    = (AC_W+1)'($signed(rnd_a[PROD_W-1:28]));
        bs    = (AC_W+1)'($signed(rnd_b[PROD_W-1:28]));
        if (mu_side_reg.neg)
            ac = -ac;
        if (vertical_reg)
        begin
            sum_x = SUM_W'(center_h_reg) + SUM_W'(bs);
            sum_y = SUM_W'(center_k_reg) + SUM_W'(ac);
        end
        else
        begin
            sum_x = SUM_W'(center_h_reg) + SUM_W'(ac);
            sum_y = SUM_W'(center_k_reg) + SUM_W'(bs);
        end
        if (mu_side_reg.err || mu_side_reg.restart)
        begin
            fn_x_next = '0;
            fn_y_next = '0;
        end
        else
        begin
            fn_x_next = sat_out(sum_x);
            fn_y_next = sat_out(sum_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fn_valid_reg <= 1'b0;
        else if (run)
            fn_valid_reg <= mu_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            fn_x_reg    <= fn_x_next;
            fn_y_reg    <= fn_y_next;
            fn_side_reg <= mu_side_reg;
        end
    end

    // output register and skid register
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  out_x_reg;
    logic signed [OUT_W-1:0]  out_y_reg;
    side_t                    out_side_reg;
    logic signed [OUT_W-1:0]  skid_x_reg;
    logic signed [OUT_W-1:0]  skid_y_reg;
    side_t                    skid_side_reg;

    logic emit;
    logic out_free;
    assign emit     = run && fn_valid_reg;
    assign out_free = ~out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || emit;
            skid_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_x_reg    <= skid_x_reg;
                out_y_reg    <= skid_y_reg;
                out_side_reg <= skid_side_reg;
            end
            else
            begin
                out_x_reg    <= fn_x_reg;
                out_y_reg    <= fn_y_reg;
                out_side_reg <= fn_side_reg;
            end
        end
        else if (emit)
        begin
            skid_x_reg    <= fn_x_reg;
            skid_y_reg    <= fn_y_reg;
            skid_side_reg <= fn_side_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = out_x_reg;
    assign pos_y       = out_y_reg;
    assign restart     = out_side_reg.restart;
    assign last_vertex = out_side_reg.last;
    assign index_error = out_side_reg.err;

    // skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a transaction while output is empty");

    // a held skid entry is not lost while the receiver stalls
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("skid transaction dropped during stall");

    // special vertices carry a zero position
    a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (index_error || restart) |-> (pos_x == '0) && (pos_y == '0))
        else $error("restart or error vertex with nonzero position");

    // flags exclude each other
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({index_error, restart, last_vertex}))
        else $error("conflicting vertex flags");

endmodule

// ===== tb/sv/hyperbola_two_branch_vertex_gen_tb.sv =====
module hyperbola_two_branch_vertex_gen_tb;

    import hvg_pkg::*;

    localparam int ITERS = CORDIC_ITERATIONS_DEF;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    restart_flag;
        logic                    last_flag;
        logic                    err_flag;
    } vertex_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic [IDX_W-1:0]      vertex_index;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [OUT_W-1:0] pos_x;
    logic signed [OUT_W-1:0] pos_y;
    logic                  restart;
    logic                  last_vertex;
    logic                  index_error;

    // shadow copy of the curve registers
    logic [A_W-1:0]        curve_a;
    logic [A_W-1:0]        curve_b;
    logic signed [C_W-1:0] curve_h;
    logic signed [C_W-1:0] curve_k;
    logic                  curve_vertical;
    logic [R_W-1:0]        curve_range;
    logic [N_W-1:0]        curve_steps;

    // cordic tables built at start
    int      shift_tab [ITERS];
    longint  atanh_tab [ITERS];
    longint  cordic_start_x;

    vertex_t expected_vertices [$];
    int      mismatch_count;
    int      hold_request;
    bit      sender_busy;

    hyperbola_two_branch_vertex_gen uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vertex_index (vertex_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .restart      (restart),
        .last_vertex  (last_vertex),
        .index_error  (index_error)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    // shift sequence, atanh constants and start value of the rotation
    function automatic void build_cordic_tables();
        int k;
        int rep;
        int s;
        int e;
        bit again;
        longint unsigned p;
        longint unsigned sum;
        longint unsigned root;
        longint unsigned bt;
        longint unsigned val;
        k = 1;
        rep = 4;
        again = 1'b0;
        p = 64'd1 << 62;
        for (int it = 0; it < ITERS; it++)
        begin
            s = k;
            if (s == rep && !again)
            begin
                again = 1'b1;
            end
            else
            begin
                if (s == rep)
                begin
                    rep = 3 * rep + 1;
                end
                again = 1'b0;
                k++;
            end
            shift_tab[it] = s;
            p = p - (p >> (2 * s));
            sum = 0;
            for (int m = 0; m < 64; m++)
            begin
                e = 62 - s * (2 * m + 1);
                if (e < 0)
                begin
                    break;
                end
                sum = sum + ((64'd1 << e) / longint'(2 * m + 1));
            end
            atanh_tab[it] = longint'((sum + (64'd1 << 33)) >> 34);
        end
        // integer square root of the gain product
        root = 0;
        bt = 64'd1 << 62;
        val = p;
        while (bt > val)
        begin
            bt = bt >> 2;
        end
        while (bt != 0)
        begin
            if (val >= root + bt)
            begin
                val = val - (root + bt);
                root = (root >> 1) + bt;
            end
            else
            begin
                root = root >> 1;
            end
            bt = bt >> 2;
        end
        if (root == 0)
        begin
            root = 1;
        end
        cordic_start_x = longint'((64'd1 << 59) / root);
    endfunction

    // cosh and sinh of a Q4.12 parameter, both in Q28
    function automatic void hyperbolic(input longint t, output longint ch, output longint sh);
        longint tq;
        longint tabs;
        longint q;
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint ep;
        longint em;
        longint pa;
        longint pb;
        longint ln2;
        ln2 = longint'(LN2_Q28);
        tq = t * 65536;
        tabs = (tq < 0) ? -tq : tq;
        q = (tabs + ln2 / 2) / ln2;
        if (tq < 0)
        begin
            q = -q;
        end
        r = tq - q * ln2;
        x = cordic_start_x;
        y = 0;
        z = r;
        for (int it = 0; it < ITERS; it++)
        begin
            dx = y >>> shift_tab[it];
            dy = x >>> shift_tab[it];
            if (z >= 0)
            begin
                x = x + dx;
                y = y + dy;
                z = z - atanh_tab[it];
            end
            else
            begin
                x = x - dx;
                y = y - dy;
                z = z + atanh_tab[it];
            end
        end
        ep = x + y;
        em = x - y;
        if (q >= 1)
            pa = ep <<< (q - 1);
        else
            pa = ep >>> (1 - q);
        if (q <= -1)
            pb = em <<< (-q - 1);
        else
            pb = em >>> (q + 1);
        ch = pa + pb;
        sh = pa - pb;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[OUT_W-1:0];
    endfunction

    function automatic longint effective_steps();
        longint n;
        n = longint'(curve_steps);
        if (n == 0)
            n = 1;
        if (n > MAX_STEPS)
            n = MAX_STEPS;
        return n;
    endfunction

    // expected vertex for one strip position
    function automatic vertex_t predict_vertex(input logic [IDX_W-1:0] idx);
        vertex_t v;
        longint n;
        longint i;
        longint j;
        longint sgn;
        longint rr;
        longint t;
        longint ch;
        longint sh;
        longint ac;
        longint bs;
        v = '0;
        n = effective_steps();
        i = longint'(idx);
        rr = longint'(curve_range);
        if (i > 2 * n + 2)
        begin
            v.err_flag = 1'b1;
        end
        else if (i == n + 1)
        begin
            v.restart_flag = 1'b1;
        end
        else
        begin
            if (i <= n)
            begin
                j = i;
                sgn = 1;
            end
            else
            begin
                j = 2 * n + 2 - i;
                sgn = -1;
                v.last_flag = (i == 2 * n + 2);
            end
            t = (4 * j * rr + n) / (2 * n) - rr;
            hyperbolic(t, ch, sh);
            ac = ((longint'(curve_a) * ch + (64'sd1 <<< 27)) >>> 28) * sgn;
            bs = (longint'(curve_b) * sh + (64'sd1 <<< 27)) >>> 28;
            if (curve_vertical)
            begin
                v.x = clamp32(longint'(curve_h) + bs);
                v.y = clamp32(longint'(curve_k) + ac);
            end
            else
            begin
                v.x = clamp32(longint'(curve_h) + ac);
                v.y = clamp32(longint'(curve_k) + bs);
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // random gap length, mostly short and a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // one register write
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wdata = data;
        @(posedge clk);
        case (addr)
            REG_SEMI_A:   curve_a = data[A_W-1:0];
            REG_SEMI_B:   curve_b = data[A_W-1:0];
            REG_CENTER_H: curve_h = data[C_W-1:0];
            REG_CENTER_K: curve_k = data[C_W-1:0];
            REG_VERTICAL: curve_vertical = data[0];
            REG_HALF_RNG: curve_range = data[R_W-1:0];
            REG_STEPS:    curve_steps = data[N_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_curve(input logic [A_W-1:0] a, input logic [A_W-1:0] b,
                             input logic [C_W-1:0] h, input logic [C_W-1:0] k,
                             input logic vert, input logic [R_W-1:0] rng,
                             input logic [N_W-1:0] n);
        write_reg(REG_SEMI_A, CFG_DATA_W'(a));
        write_reg(REG_SEMI_B, CFG_DATA_W'(b));
        write_reg(REG_CENTER_H, h);
        write_reg(REG_CENTER_K, k);
        write_reg(REG_VERTICAL, CFG_DATA_W'(vert));
        write_reg(REG_HALF_RNG, CFG_DATA_W'(rng));
        write_reg(REG_STEPS, CFG_DATA_W'(n));
    endtask

    // offer one index, hold until accepted, then optionally drop valid
    task automatic send_vertex(input logic [IDX_W-1:0] idx, input int gap);
        @(negedge clk);
        in_valid = 1'b1;
        vertex_index = idx;
        do
            @(posedge clk);
        while (!in_ready);
        expected_vertices.push_back(predict_vertex(idx));
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop offering and wait for every outstanding vertex
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid = 1'b0;
        wait (expected_vertices.size() == 0);
        @(negedge clk);
    endtask

    function automatic int next_send_gap();
        if ($urandom_range(0, 199) == 0)
            sender_busy = ~sender_busy;
        if (!sender_busy || $urandom_range(0, 9) < 6)
            return 0;
        return pick_gap();
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int n;
        int r;
        n = int'(effective_steps());
        r = $urandom_range(0, 99);
        if (r < 80)
            return IDX_W'($urandom_range(0, 2 * n + 2));
        if (r < 85)
            return IDX_W'(n + $urandom_range(0, 2));
        if (r < 90)
            return IDX_W'(2 * n + 1 + $urandom_range(0, 2));
        return IDX_W'($urandom_range(0, 4095));
    endfunction

    task automatic random_curve();
        logic [A_W-1:0] a;
        logic [A_W-1:0] b;
        logic [C_W-1:0] h;
        logic [C_W-1:0] k;
        logic [R_W-1:0] rng;
        logic [N_W-1:0] n;
        int r;
        a = ($urandom_range(0, 1) == 0) ? A_W'($urandom_range(1, 1024)) : A_W'($urandom_range(1, 65535));
        b = ($urandom_range(0, 1) == 0) ? A_W'($urandom_range(1, 1024)) : A_W'($urandom_range(1, 65535));
        h = ($urandom_range(0, 2) == 0) ? C_W'($urandom) : C_W'($urandom_range(0, 8191) - 4096);
        k = ($urandom_range(0, 2) == 0) ? C_W'($urandom) : C_W'($urandom_range(0, 8191) - 4096);
        rng = R_W'($urandom_range(1, 32767));
        r = $urandom_range(0, 99);
        if (r < 70)
            n = N_W'($urandom_range(1, 32));
        else if (r < 95)
            n = N_W'($urandom_range(33, 300));
        else
            n = N_W'($urandom_range(301, 2047));
        set_curve(a, b, h, k, 1'($urandom_range(0, 1)), rng, n);
    endtask

    // defaults after reset, both branches, restart, last vertex and past the end
    task automatic test_reset_defaults();
        logic [IDX_W-1:0] ids [8];
        ids = '{IDX_W'(0), IDX_W'(32), IDX_W'(64), IDX_W'(65),
                IDX_W'(66), IDX_W'(130), IDX_W'(131), IDX_W'(4095)};
        foreach (ids[i])
            send_vertex(ids[i], 0);
        drain_pipeline();
    endtask

    // register extremes, step count clamps, degenerate curve, unused register
    task automatic test_extreme_configs();
        set_curve(16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h800000, 1'b1, 15'h7FFF, 11'd1024);
        send_vertex(IDX_W'(0), 0);
        send_vertex(IDX_W'(1024), 0);
        send_vertex(IDX_W'(1025), 0);
        send_vertex(IDX_W'(2050), 0);
        send_vertex(IDX_W'(2051), 1);
        drain_pipeline();
        set_curve(16'd1, 16'd1, 24'h800000, 24'h7FFFFF, 1'b0, 15'd1, 11'd1);
        for (int i = 0; i < 5; i++)
            send_vertex(IDX_W'(i), 0);
        drain_pipeline();
        // zero step count acts as one, zero sizes give a degenerate curve
        set_curve(16'd0, 16'd0, 24'd0, 24'd0, 1'b0, 15'd0, 11'd0);
        send_vertex(IDX_W'(0), 0);
        send_vertex(IDX_W'(3), 0);
        send_vertex(IDX_W'(4), 1);
        drain_pipeline();
        // step count above the maximum is clamped
        write_reg(REG_STEPS, CFG_DATA_W'(2047));
        write_reg(REG_HALF_RNG, CFG_DATA_W'(8192));
        write_reg(REG_SEMI_A, CFG_DATA_W'(256));
        send_vertex(IDX_W'(2050), 0);
        send_vertex(IDX_W'(2051), 1);
        drain_pipeline();
        // write to an unused register index leaves the curve alone
        write_reg(REG_UNUSED, 24'hFFFFFF);
        send_vertex(IDX_W'(0), 1);
        drain_pipeline();
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        set_curve(16'd300, 16'd200, 24'd0, 24'd0, 1'b0, 15'd12000, 11'd40);
        hold_request = 300;
        for (int i = 0; i < 150; i++)
            send_vertex(pick_index(), 0);
        drain_pipeline();
    endtask

    task automatic test_random_strips();
        for (int ph = 0; ph < 8; ph++)
        begin
            random_curve();
            for (int i = 0; i < 140; i++)
                send_vertex(pick_index(), next_send_gap());
            drain_pipeline();
        end
    endtask

    // receiver: random stalls, quiet stretches and requested long holds
    initial
    begin
        int stall_left;
        bit recv_busy;
        stall_left = 0;
        recv_busy = 1'b1;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 299) == 0)
                recv_busy = ~recv_busy;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else if (hold_request > 0)
            begin
                stall_left = hold_request - 1;
                hold_request = 0;
                out_ready = 1'b0;
            end
            else if (recv_busy && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap() - 1;
                out_ready = 1'b0;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest expected vertex
    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_vertices.size() == 0)
            begin
                report_mismatch("unexpected transaction pos_x", pos_x, 0);
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (pos_x !== want.x)
                    report_mismatch("pos_x", pos_x, want.x);
                if (pos_y !== want.y)
                    report_mismatch("pos_y", pos_y, want.y);
                if (restart !== want.restart_flag)
                    report_mismatch("restart", restart, want.restart_flag);
                if (last_vertex !== want.last_flag)
                    report_mismatch("last_vertex", last_vertex, want.last_flag);
                if (index_error !== want.err_flag)
                    report_mismatch("index_error", index_error, want.err_flag);
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        vertex_index = '0;
        mismatch_count = 0;
        hold_request = 0;
        sender_busy = 1'b0;
        curve_a = SEMI_A_RST;
        curve_b = SEMI_B_RST;
        curve_h = '0;
        curve_k = '0;
        curve_vertical = 1'b0;
        curve_range = HALF_RNG_RST;
        curve_steps = STEPS_RST;
        build_cordic_tables();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_extreme_configs();
        test_backpressure();
        test_random_strips();

        if (expected_vertices.size() != 0)
            report_mismatch("leftover expected vertices", expected_vertices.size(), 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
